// ----- rtl/posp_pkg.sv -----
// ----------------------------------------------------------------------------
// posp_pkg
// Shared types and constants of the pulse oximeter sample processor.
// ----------------------------------------------------------------------------
`default_nettype none

package posp_pkg;

	// Default depth of the beat rate history
	localparam int HISTORY_DEPTH_DEF = 8;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_FINGER_THRESHOLD  = 3'd0,
		REG_LED_CURRENT_RATIO = 3'd1,
		REG_SPO2_OFFSET       = 3'd2,
		REG_SPO2_SLOPE        = 3'd3,
		REG_SPO2_UPPER        = 3'd4,
		REG_SPO2_LOWER        = 3'd5,
		REG_SPO2_SMOOTHING    = 3'd6
	} cfg_addr_t;

	// Register reset values
	localparam logic [17:0] FINGER_THRESHOLD_RST  = 18'd15000;
	localparam logic [11:0] LED_CURRENT_RATIO_RST = 12'd2458;
	localparam logic [15:0] SPO2_OFFSET_RST       = 16'd28160;
	localparam logic [15:0] SPO2_SLOPE_RST        = 16'd6400;
	localparam logic [14:0] SPO2_UPPER_RST        = 15'd25600;
	localparam logic [14:0] SPO2_LOWER_RST        = 15'd17920;
	localparam logic [7:0]  SPO2_SMOOTHING_RST    = 8'd230;

	// Pulse tracking constants (Q18.8 where a level)
	localparam logic [25:0] ENVELOPE_RST = 26'd256;
	localparam logic [25:0] SEED_LIMIT   = 26'd256;
	localparam logic [31:0] THR_MIN      = 32'd30720;
	localparam logic [31:0] BPM_NUMER    = 32'd15360000;
	localparam logic [31:0] INTERVAL_MIN = 32'd334;
	localparam logic [31:0] INTERVAL_MAX = 32'd1499;
	localparam logic [31:0] TIMEOUT_MS   = 32'd5000;
	localparam logic [15:0] SMOOTH_SEED  = 16'd256;

	typedef struct packed {
		logic [17:0] finger_threshold;
		logic [11:0] led_current_ratio;
		logic [15:0] spo2_offset;
		logic [15:0] spo2_slope;
		logic [14:0] spo2_upper;
		logic [14:0] spo2_lower;
		logic [7:0]  spo2_smoothing;
	} cfg_t;

	// One classified sample in the queue
	typedef struct packed {
		logic [31:0] time_ms;
		logic [17:0] ir_sample;
		logic [17:0] red_sample;
		logic        finger;
	} item_t;

endpackage

`default_nettype wire

// ----- rtl/pulse_oximeter_sample_processor.sv -----
// ----------------------------------------------------------------------------
// pulse_oximeter_sample_processor
// Heart rate and SpO2 estimation from red/IR sample pairs.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample transaction: red, IR and a millisecond stamp.
//   m_axis returns one result transaction per sample: finger flag, rate valid,
//   heart rate, smoothed SpO2 and normalized ratio.
//   cfg_we/cfg_addr/cfg_wdata write the calibration registers; write them
//   only while no sample is in flight.
//   A serial divider computes the ratio, the beat rate and the average,
//   while the divisions by 20 go through a reciprocal multiply. A sample
//   without finger or while seeding the baseline goes straight to the
//   output; a tracked sample uses the divisions by 20 and the ratio, and a
//   recorded beat adds the beat rate, history sum and average. One sample is
//   worked at a time; a two-entry queue takes the next samples meanwhile.
//   Reset clears all tracking state and outputs, empties history, loads the
//   register defaults. When m_axis stalls, the result is held in the output
//   register, the sequencer waits, then the queue fills and s_axis_tready
//   drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_oximeter_sample_processor import posp_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// red_sample[17:0], ir_sample[35:18], time_ms[67:36], zero fill
	input  wire logic [71:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// finger_present[0], rate_valid[1], heart_rate[17:2],
	// oxygen_saturation[32:18], ratio_normalized[48:33], zero fill
	output logic [55:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [17:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  q_full, q_push, q_valid, q_pop;
	item_t push_item, head_item;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.finger_threshold  <= FINGER_THRESHOLD_RST;
			cfg_q.led_current_ratio <= LED_CURRENT_RATIO_RST;
			cfg_q.spo2_offset       <= SPO2_OFFSET_RST;
			cfg_q.spo2_slope        <= SPO2_SLOPE_RST;
			cfg_q.spo2_upper        <= SPO2_UPPER_RST;
			cfg_q.spo2_lower        <= SPO2_LOWER_RST;
			cfg_q.spo2_smoothing    <= SPO2_SMOOTHING_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FINGER_THRESHOLD:  cfg_q.finger_threshold  <= cfg_wdata;
				REG_LED_CURRENT_RATIO: cfg_q.led_current_ratio <= cfg_wdata[11:0];
				REG_SPO2_OFFSET:       cfg_q.spo2_offset       <= cfg_wdata[15:0];
				REG_SPO2_SLOPE:        cfg_q.spo2_slope        <= cfg_wdata[15:0];
				REG_SPO2_UPPER:        cfg_q.spo2_upper        <= cfg_wdata[14:0];
				REG_SPO2_LOWER:        cfg_q.spo2_lower        <= cfg_wdata[14:0];
				REG_SPO2_SMOOTHING:    cfg_q.spo2_smoothing    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	posp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	posp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head_item)
	);

	posp_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ----- rtl/posp_div.sv -----
// ----------------------------------------------------------------------------
// posp_div
// Restoring 32 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module posp_div import posp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dv_q;
	logic [32:0] trial;
	logic        fits;

	// Shift in the next dividend bit and test against the divisor
	always_comb begin
		trial = {rem_q, quo_q[31]};
		fits  = trial >= {1'b0, dv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
				rem_q  <= '0;
				quo_q  <= dividend;
				dv_q   <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? 32'(trial - {1'b0, dv_q}) : trial[31:0];
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/posp_front.sv -----
// ----------------------------------------------------------------------------
// posp_front
// Accepts sample transactions, unpacks them and marks finger presence.
// ----------------------------------------------------------------------------
`default_nettype none

module posp_front import posp_pkg::*; (
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,
	input  wire cfg_t        cfg,
	input  wire logic        q_full,
	output logic             q_push,
	output item_t            q_item
);

	// Hold off while the queue is full
	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;

	// Unpack and classify
	always_comb begin
		q_item.red_sample = s_axis_tdata[17:0];
		q_item.ir_sample  = s_axis_tdata[35:18];
		q_item.time_ms    = s_axis_tdata[67:36];
		q_item.finger     = s_axis_tdata[35:18] >= cfg.finger_threshold;
	end

endmodule

`default_nettype wire

// ----- rtl/posp_queue.sv -----
// ----------------------------------------------------------------------------
// posp_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module posp_queue import posp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       valid,
	output item_t      head
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head  = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

endmodule

`default_nettype wire

// ----- rtl/posp_back.sv -----
// ----------------------------------------------------------------------------
// posp_back
// Sequencer that tracks the pulse, averages beats and estimates SpO2.
// ----------------------------------------------------------------------------
`default_nettype none

module posp_back import posp_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata
);

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = 16 + FILL_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
	// Reciprocal of 5 scaled by 2^34, rounded up
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

	typedef enum logic [16:0] {
		S_IDLE   = 17'b0_0000_0000_0000_0001,
		S_DIV    = 17'b0_0000_0000_0000_0010,
		S_BASE   = 17'b0_0000_0000_0000_0100,
		S_ENV    = 17'b0_0000_0000_0000_1000,
		S_THR    = 17'b0_0000_0000_0001_0000,
		S_BPM    = 17'b0_0000_0000_0010_0000,
		S_SUM    = 17'b0_0000_0000_0100_0000,
		S_AVG    = 17'b0_0000_0000_1000_0000,
		S_RMUL   = 17'b0_0000_0001_0000_0000,
		S_RSTART = 17'b0_0000_0010_0000_0000,
		S_RATIO  = 17'b0_0000_0100_0000_0000,
		S_SPO2   = 17'b0_0000_1000_0000_0000,
		S_SM1    = 17'b0_0001_0000_0000_0000,
		S_SM2    = 17'b0_0010_0000_0000_0000,
		S_FIN    = 17'b0_0100_0000_0000_0000,
		S_OUT    = 17'b0_1000_0000_0000_0000,
		S_MUL20  = 17'b1_0000_0000_0000_0000
	} state_t;

	state_t state_q, ret_q;

	// Current sample
	logic [17:0] red_q, ir_q;
	logic [31:0] time_q;
	logic        finger_q;

	// Tracking state
	logic [25:0] base_q, env_q;
	logic signed [26:0] ac_q;
	logic        above_q, beat_seen_q;
	logic [31:0] last_q;
	logic [15:0] hist_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q, idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [15:0] smooth_q, ratio_q;
	logic [14:0] spo2_q;
	logic [15:0] held_rate_q, held_sat_q, held_ratio_q;
	logic        held_valid_q;
	logic [31:0] prod_q, acc_q;
	logic [31:0] quo20_q;

	// Output register
	logic        out_valid_q;
	logic [55:0] out_data_q;

	// Divider hookup
	logic        div_start_q;
	logic [31:0] div_a_q, div_b_q;
	logic        div_done;
	logic [31:0] quot;

	// Combinational helpers
	logic [31:0] env27, thr, interval, since_beat;
	logic [61:0] recip_prod;
	logic signed [26:0] ac_new;
	logic [25:0] mag;
	logic        beat;
	logic [24:0] spo2_t;
	logic signed [25:0] spo2_raw, spo2_hi;
	logic [14:0] spo2_clamped;
	logic [24:0] smooth_sum;
	logic        out_free;

	posp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_comb begin
		// Divide by 20 as a quarter followed by a reciprocal multiply by 1/5
		recip_prod = 62'(div_a_q[31:2]) * 62'(RECIP5);
		ac_new   = $signed({1'b0, ir_q, 8'b0}) - $signed({1'b0, quo20_q[25:0]});
		mag      = ac_new[26] ? 26'(-ac_new) : ac_new[25:0];
		env27    = 32'({quo20_q[25:0], 4'b0}) + 32'({quo20_q[25:0], 3'b0})
			+ 32'({quo20_q[25:0], 1'b0}) + 32'(quo20_q[25:0]);
		thr      = (quo20_q < THR_MIN) ? THR_MIN : quo20_q;
		beat     = !above_q && !ac_q[26] && (32'(ac_q[25:0]) > thr);
		interval = time_q - last_q;
		since_beat = time_q - last_q;
		spo2_t   = 25'((33'(prod_q) + 33'd128) >> 8);
		spo2_raw = $signed({10'b0, cfg.spo2_offset}) - $signed({1'b0, spo2_t});
		spo2_hi  = (spo2_raw > $signed({11'b0, cfg.spo2_upper}))
			? $signed({11'b0, cfg.spo2_upper}) : spo2_raw;
		spo2_clamped = (spo2_hi < $signed({11'b0, cfg.spo2_lower}))
			? cfg.spo2_lower : spo2_hi[14:0];
		smooth_sum = 25'(acc_q) + 25'(prod_q) + 25'd128;
		out_free = !out_valid_q || m_axis_tready;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// Beat history storage
	always_ff @(posedge clk) begin
		if (state_q == S_BPM) begin
			hist_q[slot_q] <= quot[15:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			red_q        <= '0;
			ir_q         <= '0;
			time_q       <= '0;
			finger_q     <= 1'b0;
			base_q       <= '0;
			env_q        <= ENVELOPE_RST;
			ac_q         <= '0;
			above_q      <= 1'b0;
			beat_seen_q  <= 1'b0;
			last_q       <= '0;
			slot_q       <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			smooth_q     <= '0;
			ratio_q      <= '0;
			spo2_q       <= '0;
			held_rate_q  <= '0;
			held_sat_q   <= '0;
			held_ratio_q <= '0;
			held_valid_q <= 1'b0;
			prod_q       <= '0;
			acc_q        <= '0;
			quo20_q      <= '0;
			div_start_q  <= 1'b0;
			div_a_q      <= '0;
			div_b_q      <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			div_start_q <= 1'b0;
			quo20_q     <= 32'(recip_prod[61:34]);
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						red_q    <= q_item.red_sample;
						ir_q     <= q_item.ir_sample;
						time_q   <= q_item.time_ms;
						finger_q <= q_item.finger;
						if (!q_item.finger) begin
							held_valid_q <= 1'b0;
							held_rate_q  <= '0;
							held_sat_q   <= '0;
							held_ratio_q <= '0;
							base_q       <= '0;
							env_q        <= ENVELOPE_RST;
							above_q      <= 1'b0;
							state_q      <= S_OUT;
						end else if (base_q <= SEED_LIMIT) begin
							base_q  <= {q_item.ir_sample, 8'b0};
							state_q <= S_OUT;
						end else begin
							div_a_q     <= 32'({base_q, 4'b0}) + 32'({base_q, 1'b0})
								+ 32'(base_q) + 32'({q_item.ir_sample, 8'b0}) + 32'd10;
							ret_q       <= S_BASE;
							state_q     <= S_MUL20;
						end
					end
				end
				S_MUL20: begin
					// Quotient by 20 lands in quo20_q at this edge
					state_q <= ret_q;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= ret_q;
					end
				end
				S_BASE: begin
					// New baseline, AC part, envelope update
					base_q      <= quo20_q[25:0];
					ac_q        <= ac_new;
					div_a_q     <= 32'({env_q, 4'b0}) + 32'({env_q, 1'b0}) + 32'(env_q)
						+ 32'(mag) + 32'd10;
					ret_q       <= S_ENV;
					state_q     <= S_MUL20;
				end
				S_ENV: begin
					env_q       <= quo20_q[25:0];
					div_a_q     <= env27;
					ret_q       <= S_THR;
					state_q     <= S_MUL20;
				end
				S_THR: begin
					// Rising crossing of the beat threshold
					if (beat) begin
						above_q     <= 1'b1;
						beat_seen_q <= 1'b1;
						last_q      <= time_q;
						if (beat_seen_q && interval >= INTERVAL_MIN
								&& interval <= INTERVAL_MAX) begin
							div_start_q <= 1'b1;
							div_a_q     <= BPM_NUMER + {1'b0, interval[31:1]};
							div_b_q     <= interval;
							ret_q       <= S_BPM;
							state_q     <= S_DIV;
						end else begin
							state_q <= S_RMUL;
						end
					end else begin
						if (above_q && ac_q[26]) begin
							above_q <= 1'b0;
						end
						state_q <= S_RMUL;
					end
				end
				S_BPM: begin
					slot_q  <= (slot_q == SLOT_LAST) ? '0 : SLOT_W'(slot_q + 1'b1);
					if (fill_q != FILL_FULL) begin
						fill_q <= FILL_W'(fill_q + 1'b1);
					end
					sum_q   <= '0;
					idx_q   <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					// Accumulate one history entry a cycle
					if (idx_q < fill_q) begin
						sum_q <= SUM_W'(sum_q + SUM_W'(hist_q[idx_q[SLOT_W-1:0]]));
						idx_q <= FILL_W'(idx_q + 1'b1);
					end else begin
						div_start_q <= 1'b1;
						div_a_q     <= 32'(sum_q) + 32'(fill_q >> 1);
						div_b_q     <= 32'(fill_q);
						ret_q       <= S_AVG;
						state_q     <= S_DIV;
					end
				end
				S_AVG: begin
					held_rate_q  <= quot[15:0];
					held_valid_q <= 1'b1;
					state_q      <= S_RMUL;
				end
				S_RMUL: begin
					if (ir_q == '0) begin
						state_q <= S_FIN;
					end else begin
						prod_q  <= 32'(red_q * cfg.led_current_ratio);
						state_q <= S_RSTART;
					end
				end
				S_RSTART: begin
					div_start_q <= 1'b1;
					div_a_q     <= prod_q + 32'(ir_q[17:1]);
					div_b_q     <= 32'(ir_q);
					ret_q       <= S_RATIO;
					state_q     <= S_DIV;
				end
				S_RATIO: begin
					// Saturate the ratio, then apply the slope
					if (quot > 32'hFFFF) begin
						ratio_q <= 16'hFFFF;
						prod_q  <= 32'(cfg.spo2_slope * 16'hFFFF);
					end else begin
						ratio_q <= quot[15:0];
						prod_q  <= 32'(cfg.spo2_slope * quot[15:0]);
					end
					state_q <= S_SPO2;
				end
				S_SPO2: begin
					spo2_q <= spo2_clamped;
					if (smooth_q <= SMOOTH_SEED) begin
						smooth_q     <= 16'(spo2_clamped);
						held_sat_q   <= 16'(spo2_clamped);
						held_ratio_q <= ratio_q;
						state_q      <= S_FIN;
					end else begin
						prod_q  <= 32'(cfg.spo2_smoothing * smooth_q);
						state_q <= S_SM1;
					end
				end
				S_SM1: begin
					acc_q   <= prod_q;
					prod_q  <= 32'((9'd256 - 9'(cfg.spo2_smoothing)) * spo2_q);
					state_q <= S_SM2;
				end
				S_SM2: begin
					smooth_q     <= smooth_sum[23:8];
					held_sat_q   <= smooth_sum[23:8];
					held_ratio_q <= ratio_q;
					state_q      <= S_FIN;
				end
				S_FIN: begin
					// Drop the rate once beats stop arriving
					if (beat_seen_q && since_beat > TIMEOUT_MS) begin
						held_valid_q <= 1'b0;
						held_rate_q  <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {7'b0, held_ratio_q, held_sat_q[14:0], held_rate_q,
							held_valid_q, finger_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
